// File: src/fvm_pkg.sv
// Shared constants and types of the face viscosity mean unit.
// Used by every module of the block; depends on nothing.
package fvm_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PORO_W      = FRAC_BITS + 1;
  localparam int NUM_W       = 2 * VALUE_WIDTH + FRAC_BITS;
  localparam int DEN_W       = VALUE_WIDTH + FRAC_BITS + 2;
  localparam int DIV_STAGES  = VALUE_WIDTH;

  localparam logic [PORO_W-1:0] Q_ONE = PORO_W'(1) << FRAC_BITS;

  localparam logic [1:0] REG_MEAN_KIND   = 2'd0;
  localparam logic [1:0] REG_POROSITY_ON = 2'd1;

  typedef struct packed {
    logic mean_kind;
    logic porosity_on;
  } cfg_t;

  // Per-request data that rides along with a division
  typedef struct packed {
    logic                   bnd;
    logic                   sat;
    logic [VALUE_WIDTH-1:0] area;
    logic [VALUE_WIDTH-1:0] cdist;
  } div_side_t;

endpackage

// File: src/fvm_front.sv
// Front stages: porosity scaling, products and mean selection.
// Feeds the numerator and denominator of the first divider; uses fvm_pkg.
module fvm_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fvm_pkg::cfg_t                     cfg_i,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic                              command_i,
  input  logic [fvm_pkg::VALUE_WIDTH-1:0]   visc_first_i,
  input  logic [fvm_pkg::VALUE_WIDTH-1:0]   visc_second_i,
  input  logic [fvm_pkg::PORO_W-1:0]        poro_first_i,
  input  logic [fvm_pkg::PORO_W-1:0]        poro_second_i,
  input  logic [fvm_pkg::PORO_W-1:0]        face_weight_i,
  input  logic [fvm_pkg::VALUE_WIDTH-1:0]   face_area_i,
  input  logic [fvm_pkg::VALUE_WIDTH-1:0]   centre_distance_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic [fvm_pkg::NUM_W-1:0]         num_o,
  output logic [fvm_pkg::DEN_W-1:0]         den_o,
  output fvm_pkg::div_side_t                side_o
);

  localparam int VW = fvm_pkg::VALUE_WIDTH;
  localparam int FB = fvm_pkg::FRAC_BITS;
  localparam int PW = fvm_pkg::PORO_W;
  localparam int SW = VW + PW;

  logic en_a, en_b, en_c;
  logic va_q, vb_q, vc_q;

  // Stage A registers
  logic          cmd_a_q;
  logic [VW-1:0] vi_a_q, vi_a_d, vj_a_q, vj_a_d, area_a_q, dist_a_q;
  logic [PW-1:0] wc_a_q, wc_a_d, pic_a_q, pic_a_d, pjc;
  logic [SW-1:0] pa, pb;

  // Stage B registers
  logic              cmd_b_q;
  logic [2*VW-1:0]   pij_b_q;
  logic [SW-1:0]     dwi_b_q, dwj_b_q;
  logic [VW-1:0]     mean_b_q, area_b_q, dist_b_q;
  logic [PW-1:0]     bm_b_q;

  // Stage C registers
  logic [fvm_pkg::NUM_W-1:0] num_c_q, num_c_d;
  logic [fvm_pkg::DEN_W-1:0] den_c_q, den_c_d, den_sum;
  fvm_pkg::div_side_t        side_c_q;

  // Advance a stage when it is empty or its successor moves
  assign en_c    = !vc_q || ready_i;
  assign en_b    = !vb_q || en_c;
  assign en_a    = !va_q || en_b;
  assign ready_o = en_a;

  // Clamp porosities and weight, scale viscosities
  always_comb begin
    pic_a_d = (poro_first_i  > fvm_pkg::Q_ONE) ? fvm_pkg::Q_ONE : poro_first_i;
    pjc     = (poro_second_i > fvm_pkg::Q_ONE) ? fvm_pkg::Q_ONE : poro_second_i;
    wc_a_d  = (face_weight_i > fvm_pkg::Q_ONE) ? fvm_pkg::Q_ONE : face_weight_i;
    pa      = SW'(visc_first_i)  * SW'(pic_a_d);
    pb      = SW'(visc_second_i) * SW'(pjc);
    vi_a_d  = cfg_i.porosity_on ? pa[VW+FB-1:FB] : visc_first_i;
    vj_a_d  = cfg_i.porosity_on ? pb[VW+FB-1:FB] : visc_second_i;
  end

  // Form harmonic denominator and select numerator
  always_comb begin
    den_sum = fvm_pkg::DEN_W'(dwi_b_q) + fvm_pkg::DEN_W'(dwj_b_q);
    num_c_d = {pij_b_q, FB'(0)};
    den_c_d = den_sum;
    priority if (cmd_b_q) begin
      num_c_d = fvm_pkg::NUM_W'(bm_b_q);
      den_c_d = fvm_pkg::DEN_W'(1);
    end else if (!cfg_i.mean_kind) begin
      num_c_d = fvm_pkg::NUM_W'(mean_b_q);
      den_c_d = fvm_pkg::DEN_W'(1);
    end else if (den_sum == '0) begin
      num_c_d = '0;
      den_c_d = fvm_pkg::DEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) va_q <= valid_i;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      cmd_a_q  <= command_i;
      vi_a_q   <= vi_a_d;
      vj_a_q   <= vj_a_d;
      wc_a_q   <= wc_a_d;
      pic_a_q  <= pic_a_d;
      area_a_q <= face_area_i;
      dist_a_q <= centre_distance_i;
    end
    if (en_b) begin
      cmd_b_q  <= cmd_a_q;
      pij_b_q  <= (2*VW)'(vi_a_q) * (2*VW)'(vj_a_q);
      dwi_b_q  <= SW'(wc_a_q) * SW'(vi_a_q);
      dwj_b_q  <= SW'(fvm_pkg::Q_ONE - wc_a_q) * SW'(vj_a_q);
      mean_b_q <= VW'(((VW+1)'(vi_a_q) + (VW+1)'(vj_a_q)) >> 1);
      bm_b_q   <= cfg_i.porosity_on ? pic_a_q : fvm_pkg::Q_ONE;
      area_b_q <= area_a_q;
      dist_b_q <= dist_a_q;
    end
    if (en_c) begin
      num_c_q        <= num_c_d;
      den_c_q        <= den_c_d;
      side_c_q.bnd   <= cmd_b_q;
      side_c_q.sat   <= 1'b0;
      side_c_q.area  <= area_b_q;
      side_c_q.cdist <= dist_b_q;
    end
  end

  assign valid_o = vc_q;
  assign num_o   = num_c_q;
  assign den_o   = den_c_q;
  assign side_o  = side_c_q;

endmodule

// File: src/fvm_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit VALUE_WIDTH bits; uses fvm_pkg.
module fvm_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [fvm_pkg::NUM_W-1:0]       num_i,
  input  logic [fvm_pkg::DEN_W-1:0]       den_i,
  input  fvm_pkg::div_side_t              side_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [fvm_pkg::VALUE_WIDTH-1:0] quot_o,
  output fvm_pkg::div_side_t              side_o
);

  localparam int NS = fvm_pkg::DIV_STAGES;
  localparam int NW = fvm_pkg::NUM_W;
  localparam int DW = fvm_pkg::DEN_W;
  localparam int QW = fvm_pkg::VALUE_WIDTH;
  localparam int CW = NW + 2;

  logic                 v_q    [NS];
  logic [NW-1:0]        rem_q  [NS];
  logic [DW-1:0]        den_q  [NS];
  logic [QW-1:0]        quo_q  [NS];
  fvm_pkg::div_side_t   side_q [NS];
  logic                 en     [NS+1];

  assign en[NS] = ready_i;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int K = NS - 1 - s;
    logic [NW-1:0]      rem_in;
    logic [DW-1:0]      den_in;
    logic [QW-1:0]      quo_in, quo_d;
    fvm_pkg::div_side_t side_in;
    logic               v_in;
    logic [CW-1:0]      sh;
    logic               ge;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign side_in = side_q[s-1];
    end

    // Try subtracting the shifted divisor
    always_comb begin
      sh       = CW'(den_in) << K;
      ge       = CW'(rem_in) >= sh;
      quo_d    = quo_in;
      quo_d[K] = ge;
    end

    assign en[s] = !v_q[s] || en[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        rem_q[s]  <= ge ? (rem_in - sh[NW-1:0]) : rem_in;
        den_q[s]  <= den_in;
        quo_q[s]  <= quo_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];
  assign quot_o  = quo_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

// File: src/fvm_mid.sv
// Middle stages: mean times area, overflow test, second divider operands.
// Sits between the two dividers; uses fvm_pkg.
module fvm_mid (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [fvm_pkg::VALUE_WIDTH-1:0] mean_i,
  input  fvm_pkg::div_side_t              side_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [fvm_pkg::NUM_W-1:0]       num_o,
  output logic [fvm_pkg::DEN_W-1:0]       den_o,
  output fvm_pkg::div_side_t              side_o
);

  localparam int VW = fvm_pkg::VALUE_WIDTH;

  logic            vd_q, ve_q, en_d, en_e;
  logic [2*VW-1:0] prod_d_q, prod_e_q;
  logic [VW-1:0]   dist_d_q, dist_e_q;
  logic            bnd_d_q, sat_e_q;

  assign en_e    = !ve_q || ready_i;
  assign en_d    = !vd_q || en_e;
  assign ready_o = en_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (en_d) vd_q <= valid_i;
      if (en_e) ve_q <= vd_q;
    end
  end

  // Multiply by area; boundary faces divide by one in Q16.16
  always_ff @(posedge clk_i) begin
    if (en_d) begin
      prod_d_q <= (2*VW)'(mean_i) * (2*VW)'(side_i.area);
      dist_d_q <= side_i.bnd ? VW'(fvm_pkg::Q_ONE) : side_i.cdist;
      bnd_d_q  <= side_i.bnd;
    end
    if (en_e) begin
      prod_e_q <= prod_d_q;
      dist_e_q <= dist_d_q;
      sat_e_q  <= !bnd_d_q && (prod_d_q[2*VW-1:VW] >= dist_d_q);
    end
  end

  assign valid_o      = ve_q;
  assign num_o        = fvm_pkg::NUM_W'(prod_e_q);
  assign den_o        = fvm_pkg::DEN_W'(dist_e_q);
  assign side_o.bnd   = 1'b0;
  assign side_o.sat   = sat_e_q;
  assign side_o.area  = '0;
  assign side_o.cdist = dist_e_q;

endmodule

// File: src/face_viscosity_mean_unit.sv
// Face viscosity mean unit: top level with config registers and output stage.
// Pipeline stages: 3 front, 32 + 32 divider stages, 2 middle, 1 output.
// Throughput one face per cycle while the output is not stalled; the dividers take one quotient bit per stage.
// A stalled output holds the pipeline only back to the first empty stage.
// Reset (rst_ni low, asynchronous) empties all stages and clears both registers.
// Config writes are always ready and take effect from the next cycle.
module face_viscosity_mean_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic                            cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            command_i,
  input  logic [fvm_pkg::VALUE_WIDTH-1:0] visc_first_i,
  input  logic [fvm_pkg::VALUE_WIDTH-1:0] visc_second_i,
  input  logic [fvm_pkg::PORO_W-1:0]      poro_first_i,
  input  logic [fvm_pkg::PORO_W-1:0]      poro_second_i,
  input  logic [fvm_pkg::PORO_W-1:0]      face_weight_i,
  input  logic [fvm_pkg::VALUE_WIDTH-1:0] face_area_i,
  input  logic [fvm_pkg::VALUE_WIDTH-1:0] centre_distance_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [fvm_pkg::VALUE_WIDTH-1:0] face_visc_o,
  output logic                            saturated_o
);

  fvm_pkg::cfg_t cfg_q;

  logic                            f_valid, f_ready, d1_valid, d1_ready;
  logic                            m_valid, m_ready, d2_valid, d2_ready;
  logic [fvm_pkg::NUM_W-1:0]       f_num, m_num;
  logic [fvm_pkg::DEN_W-1:0]       f_den, m_den;
  fvm_pkg::div_side_t              f_side, d1_side, m_side, d2_side;
  logic [fvm_pkg::VALUE_WIDTH-1:0] d1_quot, d2_quot;

  logic                            ov_q, en_o;
  logic [fvm_pkg::VALUE_WIDTH-1:0] res_q;
  logic                            sat_q;

  // Write config registers; ignore unknown indexes
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fvm_pkg::REG_MEAN_KIND:   cfg_q.mean_kind   <= cfg_data_i;
        fvm_pkg::REG_POROSITY_ON: cfg_q.porosity_on <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fvm_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .valid_i(in_valid_i), .ready_o(in_ready_o),
    .command_i, .visc_first_i, .visc_second_i, .poro_first_i, .poro_second_i,
    .face_weight_i, .face_area_i, .centre_distance_i,
    .valid_o(f_valid), .ready_i(f_ready),
    .num_o(f_num), .den_o(f_den), .side_o(f_side)
  );

  fvm_divider u_div_mean (
    .clk_i, .rst_ni,
    .valid_i(f_valid), .ready_o(f_ready),
    .num_i(f_num), .den_i(f_den), .side_i(f_side),
    .valid_o(d1_valid), .ready_i(d1_ready),
    .quot_o(d1_quot), .side_o(d1_side)
  );

  fvm_mid u_mid (
    .clk_i, .rst_ni,
    .valid_i(d1_valid), .ready_o(d1_ready),
    .mean_i(d1_quot), .side_i(d1_side),
    .valid_o(m_valid), .ready_i(m_ready),
    .num_o(m_num), .den_o(m_den), .side_o(m_side)
  );

  fvm_divider u_div_dist (
    .clk_i, .rst_ni,
    .valid_i(m_valid), .ready_o(m_ready),
    .num_i(m_num), .den_i(m_den), .side_i(m_side),
    .valid_o(d2_valid), .ready_i(d2_ready),
    .quot_o(d2_quot), .side_o(d2_side)
  );

  // Hold the result until it is taken
  assign en_o     = !ov_q || out_ready_i;
  assign d2_ready = en_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_o) begin
      ov_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      res_q <= d2_side.sat ? '1 : d2_quot;
      sat_q <= d2_side.sat;
    end
  end

  assign out_valid_o = ov_q;
  assign face_visc_o = res_q;
  assign saturated_o = sat_q;

endmodule

// File: src/fvm_checker.sv
// Port-level checker for the face viscosity mean unit, with its bind.
// Sees only top-level ports; uses fvm_pkg for widths.
module fvm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_ready_o,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [fvm_pkg::VALUE_WIDTH-1:0] face_visc_o,
  input logic                            saturated_o
);

  // Saturated results always carry the all-ones value
  a_sat_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (face_visc_o == '1))
    else $error("saturated result not all ones");

  // A waiting result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(face_visc_o) && $stable(saturated_o)))
    else $error("stalled result changed");

  // An empty output always makes room for a request
  a_in_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o) |-> in_ready_o)
    else $error("input stalled with empty output");

  // Config writes are never stalled
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind face_viscosity_mean_unit fvm_checker u_fvm_checker (
  .clk_i, .rst_ni, .cfg_ready_o, .in_ready_o,
  .out_valid_o, .out_ready_i, .face_visc_o, .saturated_o
);

// File: bench/tb_face_viscosity_mean_unit.sv
// Testbench of the face viscosity mean unit: streams inner and boundary faces
// under random idling and checks every result against a local predictor.
// Depends on fvm_pkg and face_viscosity_mean_unit.
module tb_face_viscosity_mean_unit;

  localparam int   LATENCY   = 70;
  localparam int   WDOG_MAX  = 20000;
  localparam logic CMD_INNER = 1'b0;
  localparam logic CMD_BND   = 1'b1;

  typedef struct {
    logic        command;
    logic [31:0] visc_first;
    logic [31:0] visc_second;
    logic [16:0] poro_first;
    logic [16:0] poro_second;
    logic [16:0] face_weight;
    logic [31:0] face_area;
    logic [31:0] centre_distance;
  } face_t;

  typedef struct {
    logic [31:0] face_visc;
    logic        saturated;
  } coef_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic        cfg_data_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        command_i = 1'b0;
  logic [31:0] visc_first_i = '0;
  logic [31:0] visc_second_i = '0;
  logic [16:0] poro_first_i = '0;
  logic [16:0] poro_second_i = '0;
  logic [16:0] face_weight_i = '0;
  logic [31:0] face_area_i = '0;
  logic [31:0] centre_distance_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] face_visc_o;
  logic        saturated_o;

  logic  harmonic_on = 1'b0;
  logic  poro_on = 1'b0;
  coef_t expected_coefs[$];
  int    fail_count = 0;
  int    idle_cycles = 0;
  bit    hold_off = 1'b0;
  bit    idling_on = 1'b1;

  face_viscosity_mean_unit DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Clamp a Q1.16 factor to one
  function automatic logic [16:0] clamp_one(logic [16:0] p);
    return (p > 17'd65536) ? 17'd65536 : p;
  endfunction

  // Scale a Q16.16 value by a Q1.16 factor, truncating
  function automatic logic [31:0] poro_scale(logic [31:0] v, logic [16:0] p);
    logic [48:0] prod;
    prod = v * p;
    return prod[47:16];
  endfunction

  // Predict the face coefficient for one face
  function automatic coef_t face_coef(face_t f);
    coef_t       r;
    logic [31:0] vi, vj, m;
    logic [16:0] w;
    logic [63:0] den;
    logic [95:0] num, quo;
    logic [127:0] prod;
    vi = f.visc_first;
    vj = f.visc_second;
    r.saturated = 1'b0;
    if (f.command == CMD_BND) begin
      r.face_visc = poro_on ? poro_scale(f.face_area, clamp_one(f.poro_first))
                            : f.face_area;
      return r;
    end
    if (poro_on) begin
      vi = poro_scale(vi, clamp_one(f.poro_first));
      vj = poro_scale(vj, clamp_one(f.poro_second));
    end
    if (!harmonic_on) begin
      m = (vi >> 1) + (vj >> 1) + (vi & vj & 32'd1);
    end else begin
      w = clamp_one(f.face_weight);
      den = 64'(w) * vi + 64'(17'd65536 - w) * vj;
      if (den == 0) begin
        m = '0;
      end else begin
        num = (96'(vi) * vj) << 16;
        quo = num / den;
        m = (quo > 96'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
      end
    end
    if (f.centre_distance == 0) begin
      r.face_visc = '1;
      r.saturated = 1'b1;
    end else begin
      prod = (128'(m) * f.face_area) / f.centre_distance;
      if (prod > 128'hFFFF_FFFF) begin
        r.face_visc = '1;
        r.saturated = 1'b1;
      end else begin
        r.face_visc = prod[31:0];
      end
    end
    return r;
  endfunction

  // Offer one face and hold it until accepted
  task automatic send_face(face_t f);
    in_valid_i        <= 1'b1;
    command_i         <= f.command;
    visc_first_i      <= f.visc_first;
    visc_second_i     <= f.visc_second;
    poro_first_i      <= f.poro_first;
    poro_second_i     <= f.poro_second;
    face_weight_i     <= f.face_weight;
    face_area_i       <= f.face_area;
    centre_distance_i <= f.centre_distance;
    do @(posedge clk_i); while (!in_ready_o);
    expected_coefs.push_back(face_coef(f));
  endtask

  // Drop valid after a burst, or keep it for the next request
  task automatic gap_after(int burst_left);
    int gap;
    if (idling_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Offer one register write and hold it until accepted
  task automatic write_reg(logic [1:0] idx, logic val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == fvm_pkg::REG_MEAN_KIND) harmonic_on = val;
    else if (idx == fvm_pkg::REG_POROSITY_ON) poro_on = val;
  endtask

  // Wait until every result is back, then let the pipeline drain
  task automatic drain_all();
    @(posedge clk_i);
    while (expected_coefs.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic set_mode(logic harm, logic poro);
    drain_all();
    write_reg(fvm_pkg::REG_MEAN_KIND, harm);
    write_reg(fvm_pkg::REG_POROSITY_ON, poro);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(32'h0000_8000, 32'h0004_0000);
      3: return $urandom & 32'h00FF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] rand_frac();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom);
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic face_t rand_face();
    face_t f;
    f.command         = ($urandom_range(0, 4) == 0) ? CMD_BND : CMD_INNER;
    f.visc_first      = rand_value();
    f.visc_second     = rand_value();
    f.poro_first      = rand_frac();
    f.poro_second     = rand_frac();
    f.face_weight     = rand_frac();
    f.face_area       = rand_value();
    f.centre_distance = ($urandom_range(0, 30) == 0) ? 32'd0 : rand_value();
    return f;
  endfunction

  function automatic face_t mk(logic c, logic [31:0] vi, logic [31:0] vj,
                               logic [16:0] pi, logic [16:0] pj, logic [16:0] w,
                               logic [31:0] a, logic [31:0] d);
    face_t f;
    f.command = c; f.visc_first = vi; f.visc_second = vj; f.poro_first = pi;
    f.poro_second = pj; f.face_weight = w; f.face_area = a; f.centre_distance = d;
    return f;
  endfunction

  // Extremes, zero distance, zero harmonic denominator, clamping, boundary
  task automatic test_directed();
    face_t f[$];
    f.push_back(mk(CMD_INNER, 32'h10000, 32'h30000, 17'd65536, 17'd65536,
                   17'd32768, 32'h10000, 32'h10000));
    f.push_back(mk(CMD_INNER, '1, '1, '1, '1, '1, '1, 32'd1));
    f.push_back(mk(CMD_INNER, '0, '0, '0, '0, '0, '0, '0));
    f.push_back(mk(CMD_INNER, 32'h20000, 32'h0, 17'd65536, 17'd0, 17'd0,
                   32'h10000, 32'h10000));
    f.push_back(mk(CMD_INNER, 32'h0, 32'h50000, 17'd0, 17'd65536, 17'd65536,
                   32'h20000, 32'h8000));
    f.push_back(mk(CMD_INNER, 32'h3, 32'h1, 17'h1FFFF, 17'h10001, 17'h1FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF));
    f.push_back(mk(CMD_INNER, '1, 32'h1, 17'd1, 17'd65535, 17'd1,
                   32'h1, 32'h1));
    f.push_back(mk(CMD_BND, '1, '1, 17'h1FFFF, '1, '1, 32'hFFFF_FFFF, '0));
    f.push_back(mk(CMD_BND, '0, '0, 17'd32768, '0, '0, 32'h0003_0001, '1));
    f.push_back(mk(CMD_BND, 32'h5, 32'h7, 17'd0, 17'd3, 17'd9, 32'h1234_5678, 32'd4));
    for (int pass = 0; pass < 2; pass++) begin
      set_mode(pass[0], pass[0]);
      foreach (f[i]) begin
        send_face(f[i]);
        gap_after(0);
      end
    end
    set_mode(1'b1, 1'b0);
    foreach (f[i]) send_face(f[i]);
    in_valid_i <= 1'b0;
  endtask

  // Random faces in bursts under each register setting
  task automatic test_random(int count, logic harm, logic poro);
    int burst;
    set_mode(harm, poro);
    burst = $urandom_range(1, 20);
    for (int i = 0; i < count; i++) begin
      send_face(rand_face());
      burst--;
      if (i == count - 1) in_valid_i <= 1'b0;
      else gap_after(burst);
      if (burst <= 0) burst = $urandom_range(1, 20);
    end
  endtask

  // Receiver holds off long while the sender keeps offering, to fill the pipe
  task automatic test_backpressure();
    set_mode(1'b1, 1'b1);
    idling_on = 1'b0;
    hold_off = 1'b1;
    for (int i = 0; i < 150; i++) send_face(rand_face());
    idling_on = 1'b1;
    in_valid_i <= 1'b0;
  endtask

  // Receiver: random stall pattern, with a long hold-off when asked
  initial begin
    int n;
    @(posedge clk_i);
    forever begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      n = $urandom_range(0, 3);
      case (n)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        default: out_ready_i <= $urandom_range(0, 1);
      endcase
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk_i) begin
    coef_t exp_c;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_coefs.size() == 0) begin
        $error("unexpected result face_visc=%h", face_visc_o);
        fail_count++;
      end else begin
        exp_c = expected_coefs.pop_front();
        if (face_visc_o !== exp_c.face_visc) begin
          $error("face_visc expected %h actual %h", exp_c.face_visc, face_visc_o);
          fail_count++;
        end
        if (saturated_o !== exp_c.saturated) begin
          $error("saturated expected %b actual %b", exp_c.saturated, saturated_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no accepted request or result and no config write
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_valid_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300, 1'b0, 1'b0);
    test_random(300, 1'b1, 1'b0);
    test_random(250, 1'b0, 1'b1);
    test_backpressure();
    test_random(250, 1'b1, 1'b1);
    drain_all();
    if (fail_count == 0 && expected_coefs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
